// ===== rtl/core/rag_pkg.sv =====
// ----------------------------------------------------------------------------
// rag_pkg: shared types and constants for the random access address generator
// Field widths, register indexes, generator constants, and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package rag_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REQ_COUNT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_TOTAL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REMOTE_PCT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED        = 3'd4;

    // field widths
    localparam int ID_W       = 6;
    localparam int CNT_W      = 7;
    localparam int PAGE_W     = 32;
    localparam int PCT_W      = 7;
    localparam int WORD_W     = 64;
    localparam int LAT_W      = 32;
    localparam int LINE_OUT_W = 12;
    localparam int BYTE_W     = 44;
    localparam int REM_W      = 32;

    // generator constants
    localparam logic [WORD_W-1:0] XS_MULT    = 64'h2545_F491_4F6C_DD1D;
    localparam logic [WORD_W-1:0] SEED_RESET = 64'h9E37_79B9_7F4A_7C15;

    localparam logic [CNT_W-1:0]  REQ_COUNT_RESET  = 7'd8;
    localparam logic [PAGE_W-1:0] PAGE_TOTAL_RESET = 32'd8388608;

    // which modulo a divider pass serves
    typedef enum logic [2:0] {
        PH_SELF,
        PH_REMOTE,
        PH_OWNER,
        PH_PER,
        PH_PAGE,
        PH_LINE
    } t_phase;

    // dividend length for one divider pass
    typedef enum logic [1:0] {
        DL_8,
        DL_32,
        DL_64
    } t_div_len;

    typedef struct packed {
        logic   load_in;
        logic   rec_upd;
        logic   xs_step;
        logic   mul_ll;
        logic   mul_lh;
        logic   mul_hl;
        logic   div_start;
        logic   post;
        logic   first_mul;
        logic   fin;
        logic   publish;
        t_phase phase;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
        logic div_skip;
        logic remote_hit;
        logic out_busy;
    } t_dp_stat;

endpackage

// ===== rtl/core/rag_div.sv =====
// ----------------------------------------------------------------------------
// rag_div: shared radix-2 restoring divider
// One quotient bit per cycle; 8, 32 or 64 steps by dividend length.
// ----------------------------------------------------------------------------
module rag_div import rag_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  t_div_len          i_len,
    input  logic [WORD_W-1:0] i_dividend,
    input  logic [REM_W-1:0]  i_divisor,
    output logic              o_done,
    output logic [WORD_W-1:0] o_quot,
    output logic [REM_W-1:0]  o_rem
);

    localparam int STEP_W = $clog2(WORD_W + 1);

    logic [WORD_W-1:0] r_num;
    logic [REM_W-1:0]  r_rem;
    logic [REM_W-1:0]  r_div;
    logic [STEP_W-1:0] r_left;
    logic              r_done;

    logic [WORD_W-1:0] load_num;
    logic [STEP_W-1:0] load_left;
    logic [REM_W:0]    trial;
    logic [REM_W:0]    diff;
    logic              ge;

    always_comb begin
        unique case (i_len)
            DL_8: begin
                load_num  = i_dividend << (WORD_W - 8);
                load_left = STEP_W'(8);
            end
            DL_32: begin
                load_num  = i_dividend << (WORD_W - 32);
                load_left = STEP_W'(32);
            end
            default: begin
                load_num  = i_dividend;
                load_left = STEP_W'(WORD_W);
            end
        endcase
    end

    assign trial = {r_rem, r_num[WORD_W-1]};
    assign ge    = (trial >= {1'b0, r_div});
    assign diff  = trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_left <= load_left;
            r_done <= 1'b0;
        end else if (r_left != '0) begin
            r_left <= r_left - STEP_W'(1);
            r_done <= (r_left == STEP_W'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= load_num;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_left != '0) begin
            r_num <= {r_num[WORD_W-2:0], ge};
            r_rem <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;
    assign o_rem  = r_rem;

`ifndef SYNTH
    // remainder is always reduced below the divisor
    a_rem_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_rem < r_div))
        else $error("divider remainder not below divisor");
`endif

endmodule

// ===== rtl/core/rag_dp.sv =====
// ----------------------------------------------------------------------------
// rag_dp: datapath of the random access address generator
// Config registers, xorshift64* source with a shared 32x32 multiplier,
// region arithmetic, latency accumulators and the output register.
// ----------------------------------------------------------------------------
module rag_dp import rag_pkg::*; #(
    parameter int MAX_REQUESTERS = 64,
    parameter int PAGE_BYTES     = 4096,
    parameter int LINE_BYTES     = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_operation,
    input  logic [LAT_W-1:0]      i_latency,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic                  o_is_remote,
    output logic [ID_W-1:0]       o_owner_id,
    output logic [PAGE_W-1:0]     o_page_number,
    output logic [LINE_OUT_W-1:0] o_line_offset,
    output logic [BYTE_W-1:0]     o_byte_offset,
    output logic [WORD_W-1:0]     o_latency_sum,
    output logic [WORD_W-1:0]     o_sample_count
);

    localparam int LINES      = PAGE_BYTES / LINE_BYTES;
    localparam bit NO_LINES   = (LINES == 0);
    localparam bit LINES_POW2 = (LINES > 0) && ((LINES & (LINES - 1)) == 0);
    localparam int LINE_W     = $clog2(PAGE_BYTES);
    localparam int CNT_MAX    = (1 << CNT_W) - 1;
    localparam int N_CAP      = (MAX_REQUESTERS < CNT_MAX) ? MAX_REQUESTERS : CNT_MAX;
    localparam logic [CNT_W-1:0] N_CAP_V = CNT_W'(N_CAP);

    // mod 100 = mod 4 and mod 25; 1024 is -1 mod 25
    localparam logic [12:0] FOLD_BIAS = 13'd3075;   // 123 * 25, keeps the fold positive
    localparam logic [23:0] M25_MAGIC = 24'd5243;   // ceil(2^17 / 25)

    // configuration
    logic [ID_W-1:0]   r_own_id;
    logic [CNT_W-1:0]  r_req_cnt;
    logic [PAGE_W-1:0] r_page_total;
    logic [PCT_W-1:0]  r_remote_pct;

    // working state
    logic [WORD_W-1:0] r_rand;
    logic [WORD_W-1:0] r_acc;
    logic [WORD_W-1:0] r_sum;
    logic [WORD_W-1:0] r_count;
    logic [LAT_W-1:0]  r_lat;
    logic              r_op;
    logic              r_remote;
    logic [CNT_W-1:0]  r_self;
    logic [CNT_W-1:0]  r_owner;
    logic [PAGE_W-1:0] r_per;
    logic [PAGE_W-1:0] r_first;
    logic [PAGE_W-1:0] r_page;
    logic [LINE_W-1:0] r_line;
    logic [BYTE_W-1:0] r_byte;
    logic              r_out_valid;
    logic [10:0]       r_fold;

    logic [CNT_W-1:0]  n_eff;
    logic [PAGE_W-1:0] pages;
    logic              gate;
    logic [WORD_W-1:0] xs1;
    logic [WORD_W-1:0] xs2;
    logic [WORD_W-1:0] xs3;
    logic [31:0]       mul_a;
    logic [31:0]       mul_b;
    logic [WORD_W-1:0] prod;
    logic [CNT_W:0]    owner_sum;
    logic [CNT_W-1:0]  owner_next;
    logic [WORD_W-1:0] byte_full;
    logic [WORD_W-1:0] line_ext;
    logic [WORD_W-1:0] line_idx;

    logic [12:0]       fold_pos;
    logic [12:0]       fold_neg;
    logic [12:0]       fold_t;
    logic [10:0]       n_fold;
    logic [23:0]       m25_prod;
    logic [5:0]        m25_q;
    logic [4:0]        m25_rem;
    logic [1:0]        m100_k;
    logic [PCT_W-1:0]  rem100;

    t_div_len          div_len;
    logic [WORD_W-1:0] div_dividend;
    logic [REM_W-1:0]  div_divisor;
    logic              div_done;
    logic [WORD_W-1:0] div_quot;
    logic [REM_W-1:0]  div_rem;

    // effective requester count: zero acts as one, clamp to the cap
    always_comb begin
        if (r_req_cnt == '0) begin
            n_eff = CNT_W'(1);
        end else if (r_req_cnt > N_CAP_V) begin
            n_eff = N_CAP_V;
        end else begin
            n_eff = r_req_cnt;
        end
    end

    // last region takes the remainder
    assign pages = (r_owner == n_eff - CNT_W'(1)) ? (r_page_total - r_first) : r_per;
    assign gate  = (r_remote_pct != '0) && (n_eff > CNT_W'(1));

    // xorshift step
    assign xs1 = r_rand ^ (r_rand >> 12);
    assign xs2 = xs1 ^ (xs1 << 25);
    assign xs3 = xs2 ^ (xs2 >> 27);

    // one 32x32 product per cycle, low 64 bits of state * XS_MULT
    assign mul_a = i_cmd.mul_hl ? r_rand[63:32] : r_rand[31:0];
    assign mul_b = i_cmd.mul_lh ? XS_MULT[63:32] : XS_MULT[31:0];
    assign prod  = WORD_W'(mul_a) * WORD_W'(mul_b);

    // locality draw mod 100, two stages; the draw in r_acc holds meanwhile
    // stage 1: alternating sum of 10-bit chunks, then one more fold
    assign fold_pos = 13'(r_acc[9:0]) + 13'(r_acc[29:20]) + 13'(r_acc[49:40])
                    + 13'(r_acc[63:60]);
    assign fold_neg = 13'(r_acc[19:10]) + 13'(r_acc[39:30]) + 13'(r_acc[59:50]);
    assign fold_t   = fold_pos + FOLD_BIAS - fold_neg;
    assign n_fold   = 11'(fold_t[9:0]) + 11'd25 - 11'(fold_t[12:10]);

    always_ff @(posedge i_clk) begin
        r_fold <= n_fold;
    end

    // stage 2: exact mod 25 by reciprocal, then join with the low two bits
    assign m25_prod = 24'(r_fold) * M25_MAGIC;
    assign m25_q    = m25_prod[22:17];
    assign m25_rem  = 5'(r_fold - 11'(m25_q) * 11'd25);
    assign m100_k   = r_acc[1:0] - m25_rem[1:0];
    assign rem100   = PCT_W'(m25_rem) + PCT_W'(m100_k) * PCT_W'(25);

    // owner = (self + 1 + d) mod n, sum stays below 2n
    always_comb begin
        owner_sum = {1'b0, r_self} + {1'b0, div_rem[CNT_W-1:0]} + (CNT_W+1)'(1);
        if (owner_sum >= {1'b0, n_eff}) begin
            owner_next = CNT_W'(owner_sum - {1'b0, n_eff});
        end else begin
            owner_next = owner_sum[CNT_W-1:0];
        end
    end

    assign byte_full = WORD_W'(r_page) * WORD_W'(PAGE_BYTES) + WORD_W'(r_line);
    assign line_ext  = WORD_W'(r_line);
    assign line_idx  = r_acc & WORD_W'(LINES - 1);

    // divider operands
    always_comb begin
        unique case (i_cmd.phase)
            PH_SELF: begin
                div_dividend = WORD_W'(r_own_id);
                div_divisor  = REM_W'(n_eff);
                div_len      = DL_8;
            end
            PH_OWNER: begin
                div_dividend = r_acc;
                div_divisor  = REM_W'(n_eff - CNT_W'(1));
                div_len      = DL_64;
            end
            PH_PER: begin
                div_dividend = WORD_W'(r_page_total);
                div_divisor  = REM_W'(n_eff);
                div_len      = DL_32;
            end
            PH_PAGE: begin
                div_dividend = r_acc;
                div_divisor  = pages;
                div_len      = DL_64;
            end
            PH_LINE: begin
                div_dividend = r_acc;
                div_divisor  = REM_W'(LINES);
                div_len      = DL_64;
            end
            default: begin
                div_dividend = r_acc;
                div_divisor  = REM_W'(n_eff);
                div_len      = DL_64;
            end
        endcase
    end

    rag_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_len      (div_len),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // status back to the controller
    always_comb begin
        o_stat.div_done   = div_done;
        o_stat.remote_hit = gate && (rem100 < r_remote_pct);
        o_stat.out_busy   = r_out_valid && !i_out_ready;
        unique case (i_cmd.phase)
            PH_REMOTE: o_stat.div_skip = 1'b1;
            PH_PAGE:   o_stat.div_skip = (pages == '0);
            PH_LINE:   o_stat.div_skip = NO_LINES || LINES_POW2;
            default:   o_stat.div_skip = 1'b0;
        endcase
    end

    // config, random state, accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_id     <= '0;
            r_req_cnt    <= REQ_COUNT_RESET;
            r_page_total <= PAGE_TOTAL_RESET;
            r_remote_pct <= '0;
            r_rand       <= SEED_RESET;
            r_sum        <= '0;
            r_count      <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_OWN_ID:     r_own_id     <= i_cfg_wdata[ID_W-1:0];
                    CFG_REQ_COUNT:  r_req_cnt    <= i_cfg_wdata[CNT_W-1:0];
                    CFG_PAGE_TOTAL: r_page_total <= i_cfg_wdata[PAGE_W-1:0];
                    CFG_REMOTE_PCT: r_remote_pct <= i_cfg_wdata[PCT_W-1:0];
                    CFG_SEED:       r_rand       <= i_cfg_wdata;
                    default: ;
                endcase
            end else if (i_cmd.xs_step) begin
                r_rand <= xs3;
            end
            if (i_cmd.rec_upd) begin
                r_sum   <= r_sum + WORD_W'(r_lat);
                r_count <= r_count + WORD_W'(1);
            end
        end
    end

    // per-item working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op     <= i_operation;
            r_lat    <= i_latency;
            r_remote <= 1'b0;
            r_owner  <= '0;
            r_page   <= '0;
            r_line   <= '0;
            r_byte   <= '0;
        end
        if (i_cmd.mul_ll) begin
            r_acc <= prod;
        end else if (i_cmd.mul_lh || i_cmd.mul_hl) begin
            r_acc <= r_acc + {prod[31:0], 32'b0};
        end
        if (i_cmd.post) begin
            unique case (i_cmd.phase)
                PH_SELF: begin
                    r_self  <= div_rem[CNT_W-1:0];
                    r_owner <= div_rem[CNT_W-1:0];
                end
                PH_OWNER: begin
                    r_owner  <= owner_next;
                    r_remote <= 1'b1;
                end
                PH_PER:  r_per <= div_quot[PAGE_W-1:0];
                PH_PAGE: begin
                    if (pages == '0) begin
                        r_page <= r_first;
                    end else begin
                        r_page <= r_first + div_rem[PAGE_W-1:0];
                    end
                end
                PH_LINE: begin
                    if (NO_LINES) begin
                        r_line <= '0;
                    end else if (LINES_POW2) begin
                        r_line <= LINE_W'(line_idx * WORD_W'(LINE_BYTES));
                    end else begin
                        r_line <= LINE_W'(div_rem * REM_W'(LINE_BYTES));
                    end
                end
                default: ;
            endcase
        end
        if (i_cmd.first_mul) begin
            r_first <= PAGE_W'(r_per * PAGE_W'(r_owner));
        end
        if (i_cmd.fin) begin
            r_byte <= byte_full[BYTE_W-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.publish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            o_is_remote    <= r_remote && !r_op;
            o_owner_id     <= r_owner[ID_W-1:0];
            o_page_number  <= r_page;
            o_line_offset  <= line_ext[LINE_OUT_W-1:0];
            o_byte_offset  <= r_byte;
            o_latency_sum  <= r_sum;
            o_sample_count <= r_count;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTH
    // remote owner lands in range and never on this requester
    a_owner_remote: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.post && i_cmd.phase == PH_OWNER) |=>
            (r_owner < n_eff) && (r_owner != r_self))
        else $error("remote owner out of range or equal to self");

    // chosen page stays inside the page space
    a_page_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.post && i_cmd.phase == PH_PAGE) |=>
            (r_page < r_page_total) || (r_page_total == '0))
        else $error("page number beyond page total");
`endif

endmodule

// ===== rtl/core/rag_ctrl.sv =====
// ----------------------------------------------------------------------------
// rag_ctrl: sequencer of the random access address generator
// Steps one item through a latency record, or through draws and divider passes, to the result publish.
// ----------------------------------------------------------------------------
module rag_ctrl import rag_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_operation,
    output logic     o_in_ready,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_REC      = 12'b0000_0000_0010,
        S_XS       = 12'b0000_0000_0100,
        S_M0       = 12'b0000_0000_1000,
        S_M1       = 12'b0000_0001_0000,
        S_M2       = 12'b0000_0010_0000,
        S_DIV_GO   = 12'b0000_0100_0000,
        S_DIV_WAIT = 12'b0000_1000_0000,
        S_POST     = 12'b0001_0000_0000,
        S_FIRST    = 12'b0010_0000_0000,
        S_FIN      = 12'b0100_0000_0000,
        S_PUB      = 12'b1000_0000_0000
    } t_state;

    t_state r_st;
    t_state n_st;
    t_phase r_phase;
    t_phase n_phase;

    always_comb begin
        n_st       = r_st;
        n_phase    = r_phase;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.phase = r_phase;

        unique case (r_st)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    if (i_operation) begin
                        n_st = S_REC;
                    end else begin
                        n_st    = S_DIV_GO;
                        n_phase = PH_SELF;
                    end
                end
            end
            S_REC: begin
                o_cmd.rec_upd = 1'b1;
                n_st          = S_PUB;
            end
            S_XS: begin
                o_cmd.xs_step = 1'b1;
                n_st          = S_M0;
            end
            S_M0: begin
                o_cmd.mul_ll = 1'b1;
                n_st         = S_M1;
            end
            S_M1: begin
                o_cmd.mul_lh = 1'b1;
                n_st         = S_M2;
            end
            S_M2: begin
                o_cmd.mul_hl = 1'b1;
                n_st         = S_DIV_GO;
            end
            S_DIV_GO: begin
                if (i_stat.div_skip) begin
                    n_st = S_POST;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_st            = S_DIV_WAIT;
                end
            end
            S_DIV_WAIT: begin
                if (i_stat.div_done) begin
                    n_st = S_POST;
                end
            end
            S_POST: begin
                o_cmd.post = 1'b1;
                unique case (r_phase)
                    PH_SELF: begin
                        n_phase = PH_REMOTE;
                        n_st    = S_XS;
                    end
                    PH_REMOTE: begin
                        if (i_stat.remote_hit) begin
                            n_phase = PH_OWNER;
                            n_st    = S_XS;
                        end else begin
                            n_phase = PH_PER;
                            n_st    = S_DIV_GO;
                        end
                    end
                    PH_OWNER: begin
                        n_phase = PH_PER;
                        n_st    = S_DIV_GO;
                    end
                    PH_PER: begin
                        n_phase = PH_PAGE;
                        n_st    = S_FIRST;
                    end
                    PH_PAGE: begin
                        n_phase = PH_LINE;
                        n_st    = S_XS;
                    end
                    PH_LINE: n_st = S_FIN;
                    default: n_st = S_IDLE;
                endcase
            end
            S_FIRST: begin
                o_cmd.first_mul = 1'b1;
                n_st            = S_XS;
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_st      = S_PUB;
            end
            S_PUB: begin
                if (!i_stat.out_busy) begin
                    o_cmd.publish = 1'b1;
                    n_st          = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_phase <= PH_SELF;
        end else begin
            r_st    <= n_st;
            r_phase <= n_phase;
        end
    end

`ifndef SYNTH
    // an accepted item starts either the record path or the self-index pass
    a_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_in |=> (r_st == S_REC) || ((r_st == S_DIV_GO) && (r_phase == PH_SELF)))
        else $error("accepted item took a wrong first step");
`endif

endmodule

// ===== rtl/core/random_access_address_generator.sv =====
// ----------------------------------------------------------------------------
// random_access_address_generator: xorshift64* memory traffic generator
// Top level; sequencer plus datapath with a shared divider.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one item per transfer:
//   i_operation = 0 asks for the next access address, 1 records i_latency.
//   Every item yields exactly one result transfer on the output channel
//   (o_out_valid / i_out_ready).
//   Record items: a record state adds the latency to the sum and counts it,
//   then the publish state follows. Generate items run the radix-2
//   divider, one quotient bit per cycle, for own id mod count (8 steps),
//   pages per region (32), page pick and remote owner pick (64 each), and
//   line pick unless the line count is zero or a power of two; page pick
//   is skipped when the owner's region is empty. Each draw steps the
//   xorshift state, then forms the product in the shared 32x32 multiplier.
//   One item is in work at a time; ready returns the cycle after publish.
//   The result sits in an output register, so a new item is taken while
//   the previous result still waits; if the receiver stalls, the next
//   finished item holds in the sequencer until the register frees up.
//   Config is a plain write port (i_cfg_we, i_cfg_addr, i_cfg_wdata), to
//   be used only while idle; writing the seed also reloads the source.
//   Synchronous active-low reset restores register defaults, loads the
//   seed constant and clears the latency sum and sample count.
// ----------------------------------------------------------------------------
module random_access_address_generator import rag_pkg::*; #(
    parameter int MAX_REQUESTERS = 64,
    parameter int PAGE_BYTES     = 4096,
    parameter int LINE_BYTES     = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // input channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_operation,
    input  logic [LAT_W-1:0]      i_latency,
    // output channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_is_remote,
    output logic [ID_W-1:0]       o_owner_id,
    output logic [PAGE_W-1:0]     o_page_number,
    output logic [LINE_OUT_W-1:0] o_line_offset,
    output logic [BYTE_W-1:0]     o_byte_offset,
    output logic [WORD_W-1:0]     o_latency_sum,
    output logic [WORD_W-1:0]     o_sample_count
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // sequencer: dispatch, draw steps, divider passes, publish
    rag_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .o_in_ready  (o_in_ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    // datapath: config, random source, region math, accumulators, output reg
    rag_dp #(
        .MAX_REQUESTERS (MAX_REQUESTERS),
        .PAGE_BYTES     (PAGE_BYTES),
        .LINE_BYTES     (LINE_BYTES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_operation    (i_operation),
        .i_latency      (i_latency),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_is_remote    (o_is_remote),
        .o_owner_id     (o_owner_id),
        .o_page_number  (o_page_number),
        .o_line_offset  (o_line_offset),
        .o_byte_offset  (o_byte_offset),
        .o_latency_sum  (o_latency_sum),
        .o_sample_count (o_sample_count)
    );

endmodule
